/* hw/rtl/cau_pkg.sv */
// Shared types, constants and tables of the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_WIDTH_DEF   = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int LANE_W = 96;   // divide remainder width
    localparam int WIDE_W = 66;   // unsaturated result width
    localparam int Q_W    = 33;   // quotient bits kept
    localparam int VEC_SHIFT = 24;
    localparam int MAX_STEPS = 32;

    localparam logic signed [63:0] ANG_PI      = 64'sd3373259426;
    localparam logic signed [63:0] ANG_HALF_PI = 64'sd1686629713;
    localparam logic signed [63:0] ANG_TWO_PI  = 64'sd6746518852;
    localparam logic signed [63:0] GAIN_INV    = 64'sd652032874;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_NORM  = 3'd4,
        OP_ABS   = 3'd5,
        OP_ARG   = 3'd6,
        OP_POLAR = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // One item in flight. Field use depends on op:
    //   div:   x/y remainders, d divisor, qa/qb quotients, neg_*/ovf_* per component
    //   abs:   x radicand, z root
    //   arg:   x/y vector, z angle
    //   polar: x/y vector, z angle, neg_a angle sign, neg_b half-turn fold
    //   fin:   result already final in x/y (low WIDE_W bits)
    typedef struct packed {
        t_op              op;
        logic             fin;
        t_status          st;
        logic             neg_a;
        logic             neg_b;
        logic             ovf_a;
        logic             ovf_b;
        logic [LANE_W-1:0] x;
        logic [LANE_W-1:0] y;
        logic [63:0]      z;
        logic [63:0]      d;
        logic [Q_W-1:0]   qa;
        logic [Q_W-1:0]   qb;
    } t_lane;

    // atan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000007;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // conditional-subtract steps needed to bring a scaled angle below 2*pi
    function automatic int red_steps(input int frac_bits);
        return (frac_bits >= 29) ? 1 : 29 - frac_bits;
    endfunction

endpackage

/* hw/rtl/cau_req_if.sv */
// Request channel: operation code and two complex operands.
interface cau_req_if import cau_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         req_type;
    logic signed [VAL_W-1:0] a_re;
    logic signed [VAL_W-1:0] a_im;
    logic signed [VAL_W-1:0] b_re;
    logic signed [VAL_W-1:0] b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

/* hw/rtl/cau_res_if.sv */
// Result channel: complex result and status.
interface cau_res_if import cau_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] res_re;
    logic signed [VAL_W-1:0] res_im;
    logic [ST_W-1:0]         status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

/* hw/rtl/cau_front.sv */
// Front end: input register, product stage and per-operation lane setup.
module cau_front import cau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [OP_W-1:0]         i_req_type,
    input  logic signed [VAL_W-1:0] i_a_re,
    input  logic signed [VAL_W-1:0] i_a_im,
    input  logic signed [VAL_W-1:0] i_b_re,
    input  logic signed [VAL_W-1:0] i_b_im,
    output logic                    o_valid,
    output t_lane                   o_lane
);

    localparam int ANG_SH = 30 - FRAC_BITS;

    logic                    r_a_valid, r_b_valid, r_c_valid;
    t_op                     r_a_op, r_b_op;
    logic signed [VAL_W-1:0] r_a_ar, r_a_ai, r_a_br, r_a_bi;
    logic signed [VAL_W-1:0] r_b_ar, r_b_ai, r_b_br, r_b_bi;
    logic signed [63:0]      r_pp [8];
    logic signed [63:0]      r_pg;
    t_lane                   r_lane, n_lane;

    logic signed [64:0] s_re, s_im;
    logic [63:0]        den, sq, mag_re, mag_im;
    logic [LANE_W-1:0]  num_re, num_im;
    logic [LANE_W:0]    den_top;
    logic signed [63:0] vx, vy, pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_op  <= t_op'(i_req_type);
            r_a_ar  <= i_a_re;
            r_a_ai  <= i_a_im;
            r_a_br  <= i_b_re;
            r_a_bi  <= i_b_im;
            r_b_op  <= r_a_op;
            r_b_ar  <= r_a_ar;
            r_b_ai  <= r_a_ai;
            r_b_br  <= r_a_br;
            r_b_bi  <= r_a_bi;
            r_pp[0] <= r_a_ar * r_a_br;
            r_pp[1] <= r_a_ai * r_a_bi;
            r_pp[2] <= r_a_ar * r_a_bi;
            r_pp[3] <= r_a_ai * r_a_br;
            r_pp[4] <= r_a_ar * r_a_ar;
            r_pp[5] <= r_a_ai * r_a_ai;
            r_pp[6] <= r_a_br * r_a_br;
            r_pp[7] <= r_a_bi * r_a_bi;
            r_pg    <= r_a_ar * GAIN_INV;
            r_lane  <= n_lane;
        end
    end

    always_comb begin
        n_lane    = '0;
        n_lane.op = r_b_op;
        n_lane.st = ST_OK;
        s_re      = '0;
        s_im      = '0;
        mag_re    = '0;
        mag_im    = '0;
        num_re    = '0;
        num_im    = '0;
        den       = 64'(r_pp[6]) + 64'(r_pp[7]);
        den_top   = (LANE_W+1)'(den) << Q_W;
        sq        = 64'(r_pp[4]) + 64'(r_pp[5]);
        vx        = 64'(r_b_ar) <<< VEC_SHIFT;
        vy        = 64'(r_b_ai) <<< VEC_SHIFT;
        pv        = 64'(r_b_ai) <<< ANG_SH;
        unique case (r_b_op)
            OP_ADD: begin
                n_lane.fin = 1'b1;
                n_lane.x[WIDE_W-1:0] = WIDE_W'(r_b_ar) + WIDE_W'(r_b_br);
                n_lane.y[WIDE_W-1:0] = WIDE_W'(r_b_ai) + WIDE_W'(r_b_bi);
            end
            OP_SUB: begin
                n_lane.fin = 1'b1;
                n_lane.x[WIDE_W-1:0] = WIDE_W'(r_b_ar) - WIDE_W'(r_b_br);
                n_lane.y[WIDE_W-1:0] = WIDE_W'(r_b_ai) - WIDE_W'(r_b_bi);
            end
            OP_MUL: begin
                n_lane.fin = 1'b1;
                s_re = 65'(r_pp[0]) - 65'(r_pp[1]);
                s_im = 65'(r_pp[2]) + 65'(r_pp[3]);
                n_lane.x[WIDE_W-1:0] = WIDE_W'(s_re >>> FRAC_BITS);
                n_lane.y[WIDE_W-1:0] = WIDE_W'(s_im >>> FRAC_BITS);
            end
            OP_DIV: begin
                if (den == 64'd0) begin
                    n_lane.fin = 1'b1;
                    n_lane.st  = ST_DIV0;
                end else begin
                    s_re         = 65'(r_pp[0]) + 65'(r_pp[1]);
                    s_im         = 65'(r_pp[3]) - 65'(r_pp[2]);
                    n_lane.neg_a = s_re[64];
                    n_lane.neg_b = s_im[64];
                    mag_re       = s_re[64] ? 64'(-s_re) : 64'(s_re);
                    mag_im       = s_im[64] ? 64'(-s_im) : 64'(s_im);
                    num_re       = LANE_W'(mag_re) << FRAC_BITS;
                    num_im       = LANE_W'(mag_im) << FRAC_BITS;
                    n_lane.ovf_a = (LANE_W+1)'(num_re) >= den_top;
                    n_lane.ovf_b = (LANE_W+1)'(num_im) >= den_top;
                    n_lane.x     = num_re;
                    n_lane.y     = num_im;
                    n_lane.d     = den;
                end
            end
            OP_NORM: begin
                n_lane.fin = 1'b1;
                n_lane.x   = LANE_W'(sq >> FRAC_BITS);
            end
            OP_ABS: begin
                n_lane.x = LANE_W'(sq);
            end
            OP_ARG: begin
                if (r_b_ar == '0 && r_b_ai == '0) begin
                    n_lane.fin = 1'b1;
                end else if (vx < 0) begin
                    // pre-rotate into the right half plane
                    if (vy >= 0) begin
                        n_lane.x[63:0] = vy;
                        n_lane.y[63:0] = -vx;
                        n_lane.z       = ANG_HALF_PI;
                    end else begin
                        n_lane.x[63:0] = -vy;
                        n_lane.y[63:0] = vx;
                        n_lane.z       = -ANG_HALF_PI;
                    end
                end else begin
                    n_lane.x[63:0] = vx;
                    n_lane.y[63:0] = vy;
                end
            end
            OP_POLAR: begin
                n_lane.neg_a   = pv < 0;
                n_lane.z       = (pv < 0) ? -pv : pv;
                n_lane.x[63:0] = r_pg;
            end
            default: ;
        endcase
    end

    assign o_valid = r_c_valid;
    assign o_lane  = r_lane;

endmodule

/* hw/rtl/cau_cell.sv */
// One cell of the iteration chain: a divide bit, a root bit, a CORDIC step or an angle step.
module cau_cell import cau_pkg::*; #(
    parameter int IDX   = 0,
    parameter int NSTEP = CORDIC_STEPS_DEF,
    parameter int RED   = 13
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    localparam bit DIV_ON  = IDX < Q_W;
    localparam int DB      = DIV_ON ? Q_W - 1 - IDX : 0;
    localparam bit SQ_ON   = IDX < MAX_STEPS;
    localparam int SQ_SH   = SQ_ON ? 62 - 2 * IDX : 0;
    localparam bit VEC_ON  = IDX < NSTEP;
    localparam int VI      = VEC_ON ? IDX : 0;
    localparam bit RED_ON  = IDX < RED;
    localparam int RS      = RED_ON ? RED - 1 - IDX : 0;
    localparam bit FOLD_ON = IDX == RED;
    localparam bit ROT_ON  = (IDX > RED) && (IDX - RED - 1 < NSTEP);
    localparam int RI      = ROT_ON ? IDX - RED - 1 : 0;

    localparam logic [63:0]        RED_C = 64'(ANG_TWO_PI) << RS;
    localparam logic signed [63:0] VA    = 64'(atan_q30(VI));
    localparam logic signed [63:0] RA    = 64'(atan_q30(RI));

    logic               r_valid;
    t_lane              r_lane, n_lane;
    logic signed [63:0] cx, cy, cz, nx, ny, r;
    logic [LANE_W-1:0]  dsh;
    logic [63:0]        sbit, ssum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    always_comb begin
        n_lane = i_lane;
        cx     = $signed(i_lane.x[63:0]);
        cy     = $signed(i_lane.y[63:0]);
        cz     = $signed(i_lane.z);
        nx     = cx;
        ny     = cy;
        r      = cz;
        dsh    = LANE_W'(i_lane.d) << DB;
        sbit   = 64'd1 << SQ_SH;
        ssum   = i_lane.z + sbit;
        if (!i_lane.fin) begin
            unique case (i_lane.op)
                OP_DIV: begin
                    if (DIV_ON) begin
                        if (i_lane.x >= dsh) begin
                            n_lane.x     = i_lane.x - dsh;
                            n_lane.qa[DB] = 1'b1;
                        end
                        if (i_lane.y >= dsh) begin
                            n_lane.y     = i_lane.y - dsh;
                            n_lane.qb[DB] = 1'b1;
                        end
                    end
                end
                OP_ABS: begin
                    if (SQ_ON) begin
                        if (i_lane.x[63:0] >= ssum) begin
                            n_lane.x[63:0] = i_lane.x[63:0] - ssum;
                            n_lane.z       = (i_lane.z >> 1) + sbit;
                        end else begin
                            n_lane.z = i_lane.z >> 1;
                        end
                    end
                end
                OP_ARG: begin
                    if (VEC_ON) begin
                        if (cy >= 0) begin
                            nx = cx + (cy >>> VI);
                            ny = cy - (cx >>> VI);
                            r  = cz + VA;
                        end else begin
                            nx = cx - (cy >>> VI);
                            ny = cy + (cx >>> VI);
                            r  = cz - VA;
                        end
                        n_lane.x[63:0] = nx;
                        n_lane.y[63:0] = ny;
                        n_lane.z       = r;
                    end
                end
                OP_POLAR: begin
                    if (RED_ON) begin
                        if (i_lane.z >= RED_C) begin
                            n_lane.z = i_lane.z - RED_C;
                        end
                    end else if (FOLD_ON) begin
                        // restore sign, wrap into [-pi, pi], fold into [-pi/2, pi/2]
                        r = i_lane.neg_a ? -cz : cz;
                        if (r > ANG_PI) begin
                            r = r - ANG_TWO_PI;
                        end else if (r < -ANG_PI) begin
                            r = r + ANG_TWO_PI;
                        end
                        if (r > ANG_HALF_PI) begin
                            r            = r - ANG_PI;
                            n_lane.neg_b = 1'b1;
                        end else if (r < -ANG_HALF_PI) begin
                            r            = r + ANG_PI;
                            n_lane.neg_b = 1'b1;
                        end
                        n_lane.z = r;
                    end else if (ROT_ON) begin
                        if (cz >= 0) begin
                            nx = cx - (cy >>> RI);
                            ny = cy + (cx >>> RI);
                            r  = cz - RA;
                        end else begin
                            nx = cx + (cy >>> RI);
                            ny = cy - (cx >>> RI);
                            r  = cz + RA;
                        end
                        n_lane.x[63:0] = nx;
                        n_lane.y[63:0] = ny;
                        n_lane.z       = r;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

/* hw/rtl/cau_back.sv */
// Back end: per-operation finishing (sign, rounding) and output saturation register.
module cau_back import cau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SAT_BITS  = DATA_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_lane                   i_lane,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_res_re,
    output logic signed [VAL_W-1:0] o_res_im,
    output logic [ST_W-1:0]         o_status
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [63:0] RND = (SH > 0) ? (64'sd1 <<< (SH - 1)) : 64'sd0;
    localparam logic signed [63:0] RND30 = 64'sd1 <<< 29;
    localparam logic signed [WIDE_W-1:0] QOVF = WIDE_W'(1) <<< Q_W;
    localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) <<< (SAT_BITS - 1)) - 1;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - 1;

    logic                     r_d_valid, r_e_valid;
    logic signed [WIDE_W-1:0] r_d_re, r_d_im, n_re, n_im;
    t_status                  r_d_st;
    logic signed [VAL_W-1:0]  r_e_re, r_e_im;
    t_status                  r_e_st;

    logic signed [WIDE_W-1:0] qw_a, qw_b, s_re, s_im;
    logic signed [63:0]       cx, cy, cz;
    logic                     ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= i_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_comb begin
        cx   = $signed(i_lane.x[63:0]);
        cy   = $signed(i_lane.y[63:0]);
        cz   = $signed(i_lane.z);
        qw_a = i_lane.ovf_a ? QOVF : $signed(WIDE_W'(i_lane.qa));
        qw_b = i_lane.ovf_b ? QOVF : $signed(WIDE_W'(i_lane.qb));
        n_re = '0;
        n_im = '0;
        if (i_lane.fin) begin
            n_re = $signed(i_lane.x[WIDE_W-1:0]);
            n_im = $signed(i_lane.y[WIDE_W-1:0]);
        end else begin
            unique case (i_lane.op)
                OP_DIV: begin
                    n_re = i_lane.neg_a ? -qw_a : qw_a;
                    n_im = i_lane.neg_b ? -qw_b : qw_b;
                end
                OP_ABS: n_re = $signed(WIDE_W'(i_lane.z));
                OP_ARG: n_re = WIDE_W'((cz + RND) >>> SH);
                OP_POLAR: begin
                    if (i_lane.neg_b) begin
                        cx = -cx;
                        cy = -cy;
                    end
                    n_re = WIDE_W'((cx + RND30) >>> 30);
                    n_im = WIDE_W'((cy + RND30) >>> 30);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        ovf  = 1'b0;
        s_re = r_d_re;
        s_im = r_d_im;
        if (r_d_re > SAT_HI) begin
            s_re = SAT_HI;
            ovf  = 1'b1;
        end else if (r_d_re < SAT_LO) begin
            s_re = SAT_LO;
            ovf  = 1'b1;
        end
        if (r_d_im > SAT_HI) begin
            s_im = SAT_HI;
            ovf  = 1'b1;
        end else if (r_d_im < SAT_LO) begin
            s_im = SAT_LO;
            ovf  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_re <= n_re;
            r_d_im <= n_im;
            r_d_st <= i_lane.st;
            r_e_re <= s_re[VAL_W-1:0];
            r_e_im <= s_im[VAL_W-1:0];
            r_e_st <= (r_d_st == ST_OK && ovf) ? ST_OVF : r_d_st;
        end
    end

    assign o_valid  = r_e_valid;
    assign o_res_re = r_e_re;
    assign o_res_im = r_e_im;
    assign o_status = r_e_st;

endmodule

/* hw/rtl/complex_arithmetic_unit.sv */
// Complex arithmetic unit: add, sub, mul, div, norm, magnitude, argument, polar on Q-format operands.
//
// Usage:
//   i_req carries one request beat: req_type plus operands a and b (signed, FRAC_BITS
//   fraction bits). o_res returns exactly one beat per request, in order: res_re,
//   res_im and status (ok, saturated, divide by zero). A beat moves when valid and
//   ready are both high.
// Path and throughput:
//   Every operation takes the same path: input register, product stage, setup stage,
//   a chain of NCELL cells, a finishing stage and the saturating output register. NCELL
//   is the larger of 33 divide bits and RED + 1 + min(CORDIC_STEPS, 32) polar steps,
//   where RED is the number of angle reduction steps (13 for 16 fraction bits). One
//   beat is accepted every cycle while the output is not stalled; each cell holds one
//   item and passes it on each cycle that the chain advances.
// Stall:
//   The whole chain advances together. While the output register holds a beat that
//   the receiver does not take, every stage holds and i_req.ready is low; an empty
//   output register or an accepted output beat lets a new request in that cycle.
// Reset:
//   Synchronous, active low. Clears all stage valid flags; data registers are not reset.
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cau_req_if.sink     i_req,
    cau_res_if.source   o_res
);

    // saturation width of each result component
    localparam int SAT_BITS = (DATA_WIDTH > VAL_W) ? VAL_W : DATA_WIDTH;
    // CORDIC steps actually run
    localparam int NSTEP    = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    // angle reduction steps for polar
    localparam int RED      = red_steps(FRAC_BITS);
    localparam int NCELL    = (RED + 1 + NSTEP > Q_W) ? RED + 1 + NSTEP : Q_W;

    logic  en;
    logic  w_out_valid;
    logic  w_valid [0:NCELL];
    t_lane w_lane  [0:NCELL];

    // global advance: output slot free or being drained
    assign en          = !w_out_valid || o_res.ready;
    assign i_req.ready = en;

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_a_re     (i_req.a_re),
        .i_a_im     (i_req.a_im),
        .i_b_re     (i_req.b_re),
        .i_b_im     (i_req.b_im),
        .o_valid    (w_valid[0]),
        .o_lane     (w_lane[0])
    );

    // iteration chain: divide bits, root bits, angle reduction and CORDIC steps
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cau_cell #(
            .IDX   (g),
            .NSTEP (NSTEP),
            .RED   (RED)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    cau_back #(
        .FRAC_BITS (FRAC_BITS),
        .SAT_BITS  (SAT_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (w_valid[NCELL]),
        .i_lane   (w_lane[NCELL]),
        .o_valid  (w_out_valid),
        .o_res_re (o_res.res_re),
        .o_res_im (o_res.res_im),
        .o_status (o_res.status)
    );

    assign o_res.valid = w_out_valid;

endmodule

/* test/complex_arithmetic_unit_tb.sv */
// Self-checking testbench of the complex arithmetic unit: directed table, then random beats.
module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 800;
    localparam int WD_LIMIT  = 5000;   // cycles without any beat moving
    localparam int DRAIN_CYC = 60;     // pipeline is 43 deep

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [ST_W-1:0]    st;
    } t_cres;

    typedef struct {
        t_op                op;
        logic signed [31:0] a_re, a_im, b_re, b_im;
        bit                 typed;   // expected result given in the row
        t_cres              want;
    } t_vec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cau_req_if req_if ();
    cau_res_if res_if ();

    complex_arithmetic_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // arctangent of 2^-i, 30 fraction bits
    localparam longint ATAN_Q30 [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001,
        64'h0, 64'h0
    };

    t_cres pending_q[$];
    int    n_err = 0;
    int    n_in = 0, n_out = 0;
    int    op_cnt[8];
    int    idle_cyc = 0;
    bit    quiet = 0;        // no idling on either side while set
    int    stall_left = 0;
    bit    res_taken = 0;    // result beat moved at the last rising edge

    function automatic logic signed [31:0] clamp32(input logic signed [71:0] v,
                                                   inout bit ovf);
        if (v > 72'sd2147483647) begin
            ovf = 1;
            return 32'sh7FFFFFFF;
        end
        if (v < -72'sd2147483648) begin
            ovf = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // quotient (s * 2^16) / den, truncated toward zero, integer part capped at 2^32
    function automatic logic signed [71:0] frac_quot(input logic signed [71:0] s,
                                                     input logic [63:0] den);
        logic [63:0]  mag, ip, rm;
        logic [127:0] fr;
        logic signed [71:0] q;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        ip = mag / den;
        rm = mag % den;
        if (ip > 64'hFFFFFFFF) ip = 64'h100000000;
        fr = {rm, 16'h0} / {64'h0, den};
        q = $signed({8'h0, ip << FRAC_BITS_DEF}) + $signed({8'h0, fr[63:0]});
        return (s < 0) ? -q : q;
    endfunction

    function automatic t_cres compute_result(input t_op op,
                                             input logic signed [31:0] ar, ai, br, bi);
        t_cres r;
        bit ovf;
        logic signed [71:0] w_re, w_im, p1, p2;
        logic [63:0] den, n, root, bitv;
        longint x, y, z, nx, ny, t, ang;
        bit flip;
        ovf = 0;
        w_re = 0;
        w_im = 0;
        r.st = ST_OK;
        case (op)
            OP_ADD: begin
                w_re = 72'(ar) + 72'(br);
                w_im = 72'(ai) + 72'(bi);
            end
            OP_SUB: begin
                w_re = 72'(ar) - 72'(br);
                w_im = 72'(ai) - 72'(bi);
            end
            OP_MUL: begin
                p1 = 72'(ar) * 72'(br);
                p2 = 72'(ai) * 72'(bi);
                w_re = (p1 - p2) >>> FRAC_BITS_DEF;
                p1 = 72'(ar) * 72'(bi);
                p2 = 72'(ai) * 72'(br);
                w_im = (p1 + p2) >>> FRAC_BITS_DEF;
            end
            OP_DIV: begin
                p1 = 72'(br) * 72'(br) + 72'(bi) * 72'(bi);
                den = p1[63:0];
                if (den == 0) begin
                    r.st = ST_DIV0;
                end else begin
                    w_re = frac_quot(72'(ar) * 72'(br) + 72'(ai) * 72'(bi), den);
                    w_im = frac_quot(72'(ai) * 72'(br) - 72'(ar) * 72'(bi), den);
                end
            end
            OP_NORM: begin
                p1 = 72'(ar) * 72'(ar) + 72'(ai) * 72'(ai);
                w_re = p1 >>> FRAC_BITS_DEF;
            end
            OP_ABS: begin
                p1 = 72'(ar) * 72'(ar) + 72'(ai) * 72'(ai);
                n = p1[63:0];
                root = 0;
                bitv = 64'h1 << 62;
                for (int k = 0; k < 32; k++) begin
                    if (n >= root + bitv) begin
                        n = n - (root + bitv);
                        root = (root >> 1) + bitv;
                    end else begin
                        root = root >> 1;
                    end
                    bitv = bitv >> 2;
                end
                w_re = $signed({8'h0, root});
            end
            OP_ARG: begin
                z = 0;
                if (ar != 0 || ai != 0) begin
                    x = longint'(ar) <<< VEC_SHIFT;
                    y = longint'(ai) <<< VEC_SHIFT;
                    // left half-plane: pre-rotate by a quarter turn
                    if (x < 0) begin
                        t = x;
                        if (y >= 0) begin
                            x = y; y = -t; z = ANG_HALF_PI;
                        end else begin
                            x = -y; y = t; z = -ANG_HALF_PI;
                        end
                    end
                    for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
                        if (y >= 0) begin
                            nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q30[i];
                        end else begin
                            nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q30[i];
                        end
                        x = nx;
                        y = ny;
                    end
                end
                w_re = 72'((z + (64'sd1 <<< 13)) >>> 14);
            end
            default: begin
                ang = (longint'(ai) * 64'sd16384) % ANG_TWO_PI;
                flip = 0;
                if (ang > ANG_PI) ang -= ANG_TWO_PI;
                else if (ang < -ANG_PI) ang += ANG_TWO_PI;
                if (ang > ANG_HALF_PI) begin
                    ang -= ANG_PI; flip = 1;
                end else if (ang < -ANG_HALF_PI) begin
                    ang += ANG_PI; flip = 1;
                end
                x = longint'(ar) * GAIN_INV;
                y = 0;
                for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
                    if (ang >= 0) begin
                        nx = x - (y >>> i); ny = y + (x >>> i); ang -= ATAN_Q30[i];
                    end else begin
                        nx = x + (y >>> i); ny = y - (x >>> i); ang += ATAN_Q30[i];
                    end
                    x = nx;
                    y = ny;
                end
                if (flip) begin
                    x = -x; y = -y;
                end
                w_re = 72'((x + (64'sd1 <<< 29)) >>> 30);
                w_im = 72'((y + (64'sd1 <<< 29)) >>> 30);
            end
        endcase
        r.re = clamp32(w_re, ovf);
        r.im = clamp32(w_im, ovf);
        if (r.st == ST_OK && ovf) r.st = ST_OVF;
        return r;
    endfunction

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // one request beat; called and returns at a falling edge
    task automatic send_beat(input t_op op, input logic signed [31:0] ar, ai, br, bi,
                             input bit typed, input t_cres want);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.req_type = op;
        req_if.a_re     = ar;
        req_if.a_im     = ai;
        req_if.b_re     = br;
        req_if.b_im     = bi;
        do @(posedge i_clk); while (!req_if.ready);
        pending_q.push_back(typed ? want : compute_result(op, ar, ai, br, bi));
        op_cnt[op]++;
        n_in++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 2047)) - 32'sd1024);
            3: return $signed(32'($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
            default: return $signed($urandom());
        endcase
    endfunction

    // result side: random stall, possibly none, after each taken beat; sample at the rising edge
    always @(negedge i_clk) begin
        if (res_taken) begin
            stall_left = draw_wait();
        end
        if (stall_left > 0) begin
            res_if.ready = 1'b0;
            stall_left--;
        end else begin
            res_if.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cres e;
        res_taken = i_rst_n && res_if.valid && res_if.ready;
        if (res_taken) begin
            n_out++;
            if (pending_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result beat re=%h im=%h st=%0d", $time,
                         res_if.res_re, res_if.res_im, res_if.status);
            end else begin
                e = pending_q.pop_front();
                if (res_if.res_re !== e.re || res_if.res_im !== e.im
                        || res_if.status !== e.st) begin
                    n_err++;
                    $display("%0t: mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                             $time, e.re, e.im, e.st,
                             res_if.res_re, res_if.res_im, res_if.status);
                end
            end
        end
    end

    // watchdog: any beat moving on either side resets the count
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cyc = 0;
        end else if (i_rst_n) begin
            idle_cyc++;
            if (idle_cyc >= WD_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, pending_q.size());
                $display("** complex_arithmetic_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic t_vec row(input t_op op, input logic signed [31:0] ar, ai, br, bi,
                                 input bit typed = 0, input logic signed [31:0] er = 0,
                                 input logic signed [31:0] ei = 0,
                                 input logic [ST_W-1:0] es = ST_OK);
        t_vec v;
        v.op = op; v.a_re = ar; v.a_im = ai; v.b_re = br; v.b_im = bi;
        v.typed = typed; v.want.re = er; v.want.im = ei; v.want.st = es;
        return v;
    endfunction

    initial begin
        localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
        localparam logic signed [31:0] MINV = 32'sh80000000;
        localparam logic signed [31:0] ONE  = 32'sh00010000;
        t_vec dir_tab[$];
        t_vec v;
        t_op op;

        req_if.valid = 1'b0;
        req_if.req_type = OP_ADD;
        req_if.a_re = '0;
        req_if.a_im = '0;
        req_if.b_re = '0;
        req_if.b_im = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows: extremes, each op, special cases
        dir_tab.push_back(row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, ST_OK));
        dir_tab.push_back(row(OP_ADD, MAXV, MINV, MAXV, MINV, 1, MAXV, MINV, ST_OVF));
        dir_tab.push_back(row(OP_SUB, MINV, MAXV, 1, -1, 1, MINV, MAXV, ST_OVF));
        dir_tab.push_back(row(OP_SUB, ONE, ONE, ONE, 0, 1, 0, ONE, ST_OK));
        dir_tab.push_back(row(OP_MUL, ONE, ONE, ONE, -ONE));
        dir_tab.push_back(row(OP_MUL, MINV, MINV, MINV, MAXV));
        dir_tab.push_back(row(OP_MUL, -1, 0, 1, 0));
        dir_tab.push_back(row(OP_DIV, ONE, ONE, 0, 0, 1, 0, 0, ST_DIV0));
        dir_tab.push_back(row(OP_DIV, MAXV, MINV, 0, 0, 1, 0, 0, ST_DIV0));
        dir_tab.push_back(row(OP_DIV, ONE, 0, 0, ONE));
        dir_tab.push_back(row(OP_DIV, MAXV, MAXV, 1, 0));
        dir_tab.push_back(row(OP_DIV, MINV, MINV, MINV, MINV));
        dir_tab.push_back(row(OP_DIV, -7, 3, 3, 1));
        dir_tab.push_back(row(OP_NORM, ONE, 0, 0, 0, 1, ONE, 0, ST_OK));
        dir_tab.push_back(row(OP_NORM, MINV, MINV, 0, 0));
        dir_tab.push_back(row(OP_ABS, 3, 4, 0, 0, 1, 5, 0, ST_OK));
        dir_tab.push_back(row(OP_ABS, MINV, MINV, 0, 0));
        dir_tab.push_back(row(OP_ARG, 0, 0, MAXV, MINV, 1, 0, 0, ST_OK));
        dir_tab.push_back(row(OP_ARG, -ONE, 0, 0, 0));      // negative real axis
        dir_tab.push_back(row(OP_ARG, MINV, -1, 0, 0));
        dir_tab.push_back(row(OP_ARG, 0, MAXV, 0, 0));
        dir_tab.push_back(row(OP_POLAR, 0, ONE, 0, 0, 1, 0, 0, ST_OK));
        dir_tab.push_back(row(OP_POLAR, ONE, MAXV, 0, 0));
        dir_tab.push_back(row(OP_POLAR, -ONE, MINV, 0, 0)); // negative length
        dir_tab.push_back(row(OP_POLAR, MAXV, 32'sh00020000, 0, 0));

        foreach (dir_tab[k]) begin
            v = dir_tab[k];
            send_beat(v.op, v.a_re, v.a_im, v.b_re, v.b_im, v.typed, v.want);
        end

        // random part; quiet phases give back-to-back beats
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 100 == 0) quiet = ($urandom_range(0, 2) == 0);
            op = t_op'($urandom_range(0, 7));
            send_beat(op, rand_operand(), rand_operand(), rand_operand(), rand_operand(),
                      0, '{default: 0});
        end
        req_if.valid = 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("%0d request beats, %0d result beats", n_in, n_out);
        $display("per op add..polar: %0d %0d %0d %0d %0d %0d %0d %0d; %0d mismatches",
                 op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3],
                 op_cnt[4], op_cnt[5], op_cnt[6], op_cnt[7], n_err);
        if (n_err == 0 && pending_q.size() == 0) begin
            $display("** complex_arithmetic_unit: PASSED **");
        end else begin
            $display("** complex_arithmetic_unit: FAILED **");
        end
        $finish;
    end

endmodule
